[sv/trib_pkg.sv]
package trib_pkg;

  // Field widths
  localparam int TERM_INDEX_W = 63;
  localparam int TERM_VALUE_W = 30;

  // Index bits taken from term_index (0..62)
  localparam int INDEX_BITS = 63;

  // Modulus and Barrett reciprocal floor(2^60 / p)
  localparam logic [29:0] MODULUS      = 30'd1000000007;
  localparam logic [31:0] MODULUS_X2   = 32'd2000000014;
  localparam logic [63:0] TWO_POW_60   = 64'd1 << 60;
  localparam logic [30:0] BARRETT_MU   = 31'(TWO_POW_60 / {34'd0, MODULUS});

  // Matrix store: three banks of a 3x3 matrix, address {bank, row, col}
  localparam int RAM_DEPTH = 48;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  typedef logic [TERM_VALUE_W-1:0] word_t;
  typedef logic [1:0]              idx_t;
  typedef logic [1:0]              bank_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [3:0]              step_t;
  typedef logic [INDEX_BITS-1:0]   expo_t;

  localparam idx_t  IDX_FIRST = 2'd0;
  localparam idx_t  IDX_LAST  = 2'd2;

  localparam bank_t BANK_0 = 2'd0;
  localparam bank_t BANK_1 = 2'd1;
  localparam bank_t BANK_2 = 2'd2;

  // Program steps
  localparam step_t STEP_REQ       = 4'd0;
  localparam step_t STEP_INIT_ID   = 4'd1;
  localparam step_t STEP_INIT_COMP = 4'd2;
  localparam step_t STEP_TEST      = 4'd3;
  localparam step_t STEP_BIT       = 4'd4;
  localparam step_t STEP_MUL_ACC   = 4'd5;
  localparam step_t STEP_MUL_SQ    = 4'd6;
  localparam step_t STEP_VEC       = 4'd7;
  localparam step_t STEP_OUT       = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT_REQ,
    OP_INIT_ID,
    OP_INIT_COMP,
    OP_MUL_ACC,
    OP_MUL_SQ,
    OP_VEC,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_SMALL,
    COND_EXP_ZERO,
    COND_BIT_CLEAR
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    logic  vec;
    idx_t  k;
    addr_t waddr;
  } mac_tag_t;

  typedef struct packed {
    logic  valid;
    addr_t addr;
    word_t data;
  } ram_wr_t;

  typedef struct packed {
    logic  valid;
    word_t data;
  } mac_res_t;

  typedef struct packed {
    logic  small_load;
    word_t small_value;
    logic  out_load;
  } seq_ctl_t;

  function automatic word_t seed_value(idx_t k);
    word_t v;
    case (k)
      2'd0:    v = word_t'(1);
      2'd1:    v = word_t'(1);
      2'd2:    v = word_t'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t ident_entry(idx_t r, idx_t c);
    return (r == c) ? word_t'(1) : '0;
  endfunction

  // Companion matrix [[0,1,0],[0,0,1],[1,1,1]]
  function automatic word_t comp_entry(idx_t r, idx_t c);
    logic one;
    one = (r == IDX_LAST) || (c == r + 2'd1);
    return one ? word_t'(1) : '0;
  endfunction

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      STEP_REQ:       w = '{op: OP_WAIT_REQ,  cond: COND_SMALL,     target: STEP_OUT};
      STEP_INIT_ID:   w = '{op: OP_INIT_ID,   cond: COND_NONE,      target: STEP_REQ};
      STEP_INIT_COMP: w = '{op: OP_INIT_COMP, cond: COND_NONE,      target: STEP_REQ};
      STEP_TEST:      w = '{op: OP_NOP,       cond: COND_EXP_ZERO,  target: STEP_VEC};
      STEP_BIT:       w = '{op: OP_NOP,       cond: COND_BIT_CLEAR, target: STEP_MUL_SQ};
      STEP_MUL_ACC:   w = '{op: OP_MUL_ACC,   cond: COND_NONE,      target: STEP_REQ};
      STEP_MUL_SQ:    w = '{op: OP_MUL_SQ,    cond: COND_ALWAYS,    target: STEP_TEST};
      STEP_VEC:       w = '{op: OP_VEC,       cond: COND_NONE,      target: STEP_REQ};
      STEP_OUT:       w = '{op: OP_OUT,       cond: COND_ALWAYS,    target: STEP_REQ};
      default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: STEP_REQ};
    endcase
    return w;
  endfunction

endpackage

[sv/trib_ram.sv]
module trib_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[sv/trib_mac.sv]
module trib_mac (
  input  logic               clk,
  input  logic               rst,
  input  trib_pkg::mac_tag_t tag_in,
  input  trib_pkg::word_t    rdata_a,
  input  trib_pkg::word_t    rdata_b,
  output trib_pkg::ram_wr_t  wr,
  output trib_pkg::mac_res_t res,
  output logic               pipe_empty
);
  import trib_pkg::*;

  localparam int STAGES = 6;

  mac_tag_t    tag [STAGES];
  logic [59:0] prod;
  logic [59:0] prod2;
  logic [61:0] quot;
  logic [31:0] prod3;
  logic [31:0] qp;
  logic [31:0] rem;
  word_t       red;
  word_t       accum;

  word_t       op_b;
  logic [31:0] qp_c;
  word_t       red_c;
  word_t       base;
  logic [30:0] sum;
  word_t       accum_next;
  logic        any_valid;

  // Tag line; entry 0 lines up with the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        tag[s].valid <= 1'b0;
      end
      wr.valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      tag[0] <= tag_in;
      for (int s = 1; s < STAGES; s++) begin
        tag[s] <= tag[s-1];
      end
      wr.valid  <= tag[STAGES-1].valid && tag[STAGES-1].last && !tag[STAGES-1].vec;
      res.valid <= tag[STAGES-1].valid && tag[STAGES-1].last && tag[STAGES-1].vec;
    end
    wr.addr  <= tag[STAGES-1].waddr;
    wr.data  <= accum_next;
    res.data <= accum_next;
  end

  always_comb begin
    op_b  = tag[0].vec ? seed_value(tag[0].k) : rdata_b;
    qp_c  = {1'b0, quot[61:31]} * {2'b00, MODULUS};
    if (rem >= MODULUS_X2) begin
      red_c = word_t'(rem - MODULUS_X2);
    end else if (rem >= {2'b00, MODULUS}) begin
      red_c = word_t'(rem - {2'b00, MODULUS});
    end else begin
      red_c = rem[29:0];
    end
    base = tag[STAGES-1].first ? '0 : accum;
    sum  = {1'b0, base} + {1'b0, red};
    accum_next = (sum >= {1'b0, MODULUS}) ? word_t'(sum - {1'b0, MODULUS}) : sum[29:0];
  end

  // Multiply, Barrett quotient, product of quotient, subtract, correct, accumulate
  always_ff @(posedge clk) begin
    prod  <= rdata_a * op_b;
    quot  <= prod[59:29] * BARRETT_MU;
    prod2 <= prod;
    qp    <= qp_c;
    prod3 <= prod2[31:0];
    rem   <= prod3 - qp;
    red   <= red_c;
    if (tag[STAGES-1].valid) begin
      accum <= accum_next;
    end
  end

  always_comb begin
    any_valid = wr.valid || res.valid;
    for (int s = 0; s < STAGES; s++) begin
      any_valid = any_valid || tag[s].valid;
    end
    pipe_empty = !any_valid;
  end

endmodule

[sv/trib_seq.sv]
module trib_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [trib_pkg::TERM_INDEX_W-1:0]   term_index,
  input  logic                                pipe_empty,
  input  logic                                out_free,
  output trib_pkg::mac_tag_t                  tag,
  output trib_pkg::addr_t                     raddr_a,
  output trib_pkg::addr_t                     raddr_b,
  output trib_pkg::ram_wr_t                   init_wr,
  output trib_pkg::seq_ctl_t                  ctl
);
  import trib_pkg::*;

  step_t  step;
  step_t  step_next;
  idx_t   row;
  idx_t   col;
  idx_t   dot;
  logic   issued_all;
  expo_t  expo;
  bank_t  acc_sel;
  bank_t  sq_sel;
  bank_t  tmp_sel;

  ucode_t uc;
  expo_t  n;
  logic   seed_req;
  logic   op_done;
  logic   issue;
  logic   last_elem;
  logic   cond_true;
  bank_t  a_bank;
  idx_t   a_row;

  assign uc       = ucode_rom(step);
  assign n        = term_index[INDEX_BITS-1:0];
  assign seed_req = (n <= expo_t'(2));

  always_comb begin
    in_ready        = 1'b0;
    op_done         = 1'b0;
    issue           = 1'b0;
    last_elem       = 1'b0;
    init_wr         = '0;
    ctl             = '0;
    ctl.small_value = seed_value(n[1:0]);
    case (uc.op)
      OP_WAIT_REQ: begin
        in_ready       = 1'b1;
        op_done        = in_valid;
        ctl.small_load = in_valid && seed_req;
      end
      OP_INIT_ID: begin
        init_wr.valid = 1'b1;
        init_wr.addr  = {acc_sel, row, col};
        init_wr.data  = ident_entry(row, col);
        op_done       = (row == IDX_LAST) && (col == IDX_LAST);
      end
      OP_INIT_COMP: begin
        init_wr.valid = 1'b1;
        init_wr.addr  = {sq_sel, row, col};
        init_wr.data  = comp_entry(row, col);
        op_done       = (row == IDX_LAST) && (col == IDX_LAST);
      end
      OP_MUL_ACC, OP_MUL_SQ: begin
        issue     = !issued_all;
        last_elem = (row == IDX_LAST) && (col == IDX_LAST) && (dot == IDX_LAST);
        op_done   = issued_all && pipe_empty;
      end
      OP_VEC: begin
        issue     = !issued_all;
        last_elem = (dot == IDX_LAST);
        op_done   = issued_all && pipe_empty;
      end
      OP_OUT: begin
        ctl.out_load = out_free;
        op_done      = out_free;
      end
      default: begin
        op_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (uc.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_SMALL:     cond_true = seed_req;
      COND_EXP_ZERO:  cond_true = (expo == '0);
      COND_BIT_CLEAR: cond_true = !expo[0];
      default:        cond_true = 1'b0;
    endcase
    if (!op_done) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = uc.target;
    end else begin
      step_next = step + 4'd1;
    end
  end

  always_comb begin
    a_bank      = (uc.op == OP_MUL_SQ) ? sq_sel : acc_sel;
    a_row       = (uc.op == OP_VEC) ? IDX_LAST : row;
    raddr_a     = {a_bank, a_row, dot};
    raddr_b     = {sq_sel, dot, col};
    tag.valid   = issue;
    tag.first   = (dot == IDX_FIRST);
    tag.last    = (dot == IDX_LAST);
    tag.vec     = (uc.op == OP_VEC);
    tag.k       = dot;
    tag.waddr   = {tmp_sel, row, col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_REQ;
      row        <= IDX_FIRST;
      col        <= IDX_FIRST;
      dot        <= IDX_FIRST;
      issued_all <= 1'b0;
    end else begin
      step <= step_next;
      if (op_done) begin
        row        <= IDX_FIRST;
        col        <= IDX_FIRST;
        dot        <= IDX_FIRST;
        issued_all <= 1'b0;
      end else if (init_wr.valid) begin
        if (col == IDX_LAST) begin
          col <= IDX_FIRST;
          row <= row + 2'd1;
        end else begin
          col <= col + 2'd1;
        end
      end else if (issue) begin
        if (last_elem) begin
          issued_all <= 1'b1;
        end else if (dot == IDX_LAST) begin
          dot <= IDX_FIRST;
          if (col == IDX_LAST) begin
            col <= IDX_FIRST;
            row <= row + 2'd1;
          end else begin
            col <= col + 2'd1;
          end
        end else begin
          dot <= dot + 2'd1;
        end
      end
    end
  end

  // Exponent and bank renaming; results land in the spare bank, then swap names
  always_ff @(posedge clk) begin
    if (op_done) begin
      case (uc.op)
        OP_WAIT_REQ: begin
          expo    <= n - expo_t'(2);
          acc_sel <= BANK_0;
          sq_sel  <= BANK_1;
          tmp_sel <= BANK_2;
        end
        OP_MUL_ACC: begin
          acc_sel <= tmp_sel;
          tmp_sel <= acc_sel;
        end
        OP_MUL_SQ: begin
          sq_sel  <= tmp_sel;
          tmp_sel <= sq_sel;
          expo    <= expo >> 1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/tribonacci_mod_prime_matrix_power_unit.sv]
// Returns term n of x0=1, x1=1, x2=2, xk=x(k-1)+x(k-2)+x(k-3) modulo 1000000007.
// One request on term_index gives one result on term_value; only the low
// INDEX_BITS bits of term_index count. Indexes 0..2 answer from the seed.
// Larger n raise the companion matrix to n-2 by square-and-multiply on the
// single multiply-and-reduce pipeline, which takes one product per cycle
// and is drained after each 27-product matrix multiply. One request is in work
// at a time; a finished result waits in the output register while the next
// request is accepted.
module tribonacci_mod_prime_matrix_power_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [trib_pkg::TERM_INDEX_W-1:0]  term_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [trib_pkg::TERM_VALUE_W-1:0]  term_value
);
  import trib_pkg::*;

  mac_tag_t tag;
  addr_t    raddr_a;
  addr_t    raddr_b;
  word_t    rdata_a;
  word_t    rdata_b;
  ram_wr_t  init_wr;
  ram_wr_t  mac_wr;
  ram_wr_t  ram_wr;
  mac_res_t mac_res;
  seq_ctl_t ctl;
  logic     pipe_empty;
  logic     out_free;
  word_t    result;

  // The output slot can take a new result when empty or being drained now
  assign out_free = !out_valid || out_ready;

  // Sequencer: microcode table, element counters, exponent and bank names
  trib_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .term_index (term_index),
    .pipe_empty (pipe_empty),
    .out_free   (out_free),
    .tag        (tag),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .init_wr    (init_wr),
    .ctl        (ctl)
  );

  // Merge the write port: initial fills and product write-back never overlap
  always_comb begin
    ram_wr = init_wr.valid ? init_wr : mac_wr;
  end

  // Matrix store: accumulator, square and spare matrix, one bank each
  trib_ram #(
    .WIDTH (TERM_VALUE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_wr.valid),
    .waddr   (ram_wr.addr),
    .wdata   (ram_wr.data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Modular multiply, Barrett reduce and three-term accumulate
  trib_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .tag_in     (tag),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .wr         (mac_wr),
    .res        (mac_res),
    .pipe_empty (pipe_empty)
  );

  // Hold the term until the output slot frees up
  always_ff @(posedge clk) begin
    if (ctl.small_load) begin
      result <= ctl.small_value;
    end else if (mac_res.valid) begin
      result <= mac_res.data;
    end
  end

  // Advance the result into the output register; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      term_value <= result;
    end
  end

endmodule
